FILE: rtl/core/range_pool_allocator_with_free_list_core_defines.svh
// Assertion macros shared by the identifier pool allocator RTL.
`ifndef RANGE_POOL_ALLOCATOR_WITH_FREE_LIST_CORE_DEFINES_SVH
`define RANGE_POOL_ALLOCATOR_WITH_FREE_LIST_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpa assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpa assertion failed");

`endif

FILE: rtl/core/rpa_pkg.sv
// Package with types and constants of the identifier pool allocator.
package rpa_pkg;

  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_RETURN  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANT      = 3'd0,
    STAT_SHORT      = 3'd1,
    STAT_RETURNED   = 3'd2,
    STAT_EMPTY_DONE = 3'd3,
    STAT_LIST_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_RESERVE  = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_RETURN   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_GRANT = 1'b1
  } bk_state_t;

endpackage

FILE: rtl/core/rpa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rpa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/rpa_front.sv
// Front end: accepts commands and classifies them for the back end.
module rpa_front #(
  parameter int MAX_RESERVE = 64
) (
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [rpa_pkg::COUNT_W-1:0] in_count,
  input  logic                        q_full,
  output logic                        q_push,
  output rpa_pkg::cmd_t               q_cmd
);

  localparam logic [rpa_pkg::COUNT_W-1:0] MaxRes = rpa_pkg::COUNT_W'(MAX_RESERVE);

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_cmd.count = in_count;
    if (in_op == rpa_pkg::OP_RETURN) begin
      q_cmd.kind = rpa_pkg::KIND_RETURN;
    end else if (in_count > MaxRes) begin
      q_cmd.kind = rpa_pkg::KIND_OVERSIZE;
    end else begin
      q_cmd.kind = rpa_pkg::KIND_RESERVE;
    end
  end

endmodule

FILE: rtl/core/rpa_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module rpa_cmd_fifo #(
  parameter int WIDTH = 57
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/rpa_back.sv
// Back end: free count check, free list, fresh counter and result issue.
module rpa_back #(
  parameter int ELEMENT_WIDTH   = 48,
  parameter int FREE_LIST_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ELEMENT_WIDTH-1:0]      cfg_wdata,
  input  logic                          q_empty,
  input  rpa_pkg::cmd_t                 q_cmd,
  input  logic [ELEMENT_WIDTH-1:0]      q_element,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [rpa_pkg::STATUS_W-1:0]  out_status,
  output logic [ELEMENT_WIDTH-1:0]      out_granted_element,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(FREE_LIST_DEPTH);
  localparam int ENT_W = $clog2(FREE_LIST_DEPTH + 1);
  localparam int CNT_W = ELEMENT_WIDTH + 1;
  localparam int CW    = rpa_pkg::COUNT_W;

  localparam logic [IDX_W-1:0] IdxTop  = IDX_W'(FREE_LIST_DEPTH - 1);
  localparam logic [ENT_W-1:0] EntFull = ENT_W'(FREE_LIST_DEPTH);

  rpa_pkg::bk_state_t state_r, state_nxt;

  logic [ELEMENT_WIDTH-1:0] low_r, low_nxt;
  logic [ELEMENT_WIDTH-1:0] high_r, high_nxt;
  logic [ELEMENT_WIDTH-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0]         fc_r, fc_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [IDX_W-1:0]         tail_r, tail_nxt;
  logic [ENT_W-1:0]         ent_r, ent_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;

  logic                     iss_vld_r, iss_vld_nxt;
  rpa_pkg::status_t         iss_status_r, iss_status_nxt;
  logic                     iss_list_r, iss_list_nxt;
  logic [ELEMENT_WIDTH-1:0] iss_elem_r, iss_elem_nxt;
  logic                     iss_last_r, iss_last_nxt;

  logic [IDX_W-1:0]         head_dn;
  logic [IDX_W-1:0]         tail_dn;
  logic                     take;
  logic                     res_enough;
  logic                     res_go;
  logic                     ram_we;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  assign head_dn    = (head_r == '0) ? IdxTop : head_r - 1'b1;
  assign tail_dn    = (tail_r == '0) ? IdxTop : tail_r - 1'b1;
  assign take       = (state_r == rpa_pkg::BK_IDLE) && !q_empty;
  assign res_enough = fc_r > CNT_W'(q_cmd.count);
  assign res_go     = (q_cmd.kind == rpa_pkg::KIND_RESERVE) && res_enough &&
                      (q_cmd.count != '0);

  rpa_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (FREE_LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_dn),
    .wdata (q_element),
    .raddr (tail_dn),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpa_pkg::BK_IDLE: begin
        if (take && res_go) begin
          state_nxt = rpa_pkg::BK_GRANT;
        end
      end
      rpa_pkg::BK_GRANT: begin
        if (rem_r == CW'(1)) begin
          state_nxt = rpa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rpa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    low_nxt        = low_r;
    high_nxt       = high_r;
    fresh_nxt      = fresh_r;
    fc_nxt         = fc_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ent_nxt        = ent_r;
    rem_nxt        = rem_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    iss_vld_nxt    = 1'b0;
    iss_status_nxt = rpa_pkg::STAT_GRANT;
    iss_list_nxt   = 1'b0;
    iss_elem_nxt   = '0;
    iss_last_nxt   = 1'b1;
    case (state_r)
      rpa_pkg::BK_IDLE: begin
        if (take) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            rpa_pkg::KIND_RETURN: begin
              iss_vld_nxt = 1'b1;
              if (ent_r == EntFull) begin
                iss_status_nxt = rpa_pkg::STAT_LIST_FULL;
              end else begin
                ram_we         = 1'b1;
                head_nxt       = head_dn;
                ent_nxt        = ent_r + ENT_W'(1);
                fc_nxt         = fc_r + CNT_W'(1);
                iss_status_nxt = rpa_pkg::STAT_RETURNED;
              end
            end
            rpa_pkg::KIND_RESERVE: begin
              if (!res_enough) begin
                iss_vld_nxt    = 1'b1;
                iss_status_nxt = rpa_pkg::STAT_SHORT;
              end else if (q_cmd.count == '0) begin
                iss_vld_nxt    = 1'b1;
                iss_status_nxt = rpa_pkg::STAT_EMPTY_DONE;
              end else begin
                rem_nxt = q_cmd.count;
              end
            end
            default: begin
              iss_vld_nxt    = 1'b1;
              iss_status_nxt = rpa_pkg::STAT_SHORT;
            end
          endcase
        end
      end
      rpa_pkg::BK_GRANT: begin
        iss_vld_nxt  = 1'b1;
        iss_last_nxt = (rem_r == CW'(1));
        rem_nxt      = rem_r - CW'(1);
        fc_nxt       = fc_r - CNT_W'(1);
        if (ent_r != '0) begin
          tail_nxt     = tail_dn;
          ent_nxt      = ent_r - ENT_W'(1);
          iss_list_nxt = 1'b1;
        end else begin
          iss_elem_nxt = fresh_r;
          fresh_nxt    = fresh_r + ELEMENT_WIDTH'(1);
        end
      end
      default: begin
        rem_nxt = '0;
      end
    endcase
    if (cfg_we) begin
      if (cfg_index == rpa_pkg::CFG_RANGE_LOW) begin
        low_nxt   = cfg_wdata;
        fresh_nxt = cfg_wdata;
        fc_nxt    = ({1'b0, high_r} - {1'b0, cfg_wdata}) + CNT_W'(ent_r);
      end else begin
        high_nxt  = cfg_wdata;
        fresh_nxt = low_r;
        fc_nxt    = ({1'b0, cfg_wdata} - {1'b0, low_r}) + CNT_W'(ent_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rpa_pkg::BK_IDLE;
      low_r     <= '0;
      high_r    <= '0;
      fresh_r   <= '0;
      fc_r      <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      ent_r     <= '0;
      rem_r     <= '0;
      iss_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      fresh_r   <= fresh_nxt;
      fc_r      <= fc_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      ent_r     <= ent_nxt;
      rem_r     <= rem_nxt;
      iss_vld_r <= iss_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_status_r <= iss_status_nxt;
    iss_list_r   <= iss_list_nxt;
    iss_elem_r   <= iss_elem_nxt;
    iss_last_r   <= iss_last_nxt;
  end

  assign out_valid           = iss_vld_r;
  assign out_status          = iss_status_r;
  assign out_granted_element = iss_list_r ? ram_rdata : iss_elem_r;
  assign out_last            = iss_last_r;

endmodule

FILE: rtl/core/range_pool_allocator_with_free_list_core.sv
// Top level of the identifier pool allocator with a recycling free list.
//
// Commands enter on start/busy: a command is taken at a clock edge where start
// is high and busy is low. A reserve (in_op low) asks for in_count identifiers,
// a return (in_op high) hands in_element back to the free list.
// Results leave on out_valid for exactly one cycle each and cannot be held off.
// A successful reserve of N gives N grant transactions on consecutive cycles,
// the last one with out_last set; every other command gives one transaction.
// A command with a single result reaches the result ports through the command
// queue and the issue registers when the back end is free; the first grant of
// a reserve also passes the grant state. The back end takes one command per
// cycle, and a reserve of N holds it while it issues N grants, one per cycle.
// A two-entry command queue lets the front keep taking commands meanwhile;
// busy is high while that queue is full.
// Configuration writes on cfg_we set range_low (index 0) or range_high
// (index 1) and reload the fresh counter and the free count; the user must
// make them only while no command is in flight; the block does not enforce it.
// Reset clears the counters, the list pointers and the queue; the free list
// RAM needs no clearing since only pushed entries are ever read.
module range_pool_allocator_with_free_list_core #(
  parameter int ELEMENT_WIDTH   = 48,
  parameter int FREE_LIST_DEPTH = 256,
  parameter int MAX_RESERVE     = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [rpa_pkg::COUNT_W-1:0]   in_count,
  input  logic [ELEMENT_WIDTH-1:0]      in_element,
  output logic                          out_valid,
  output logic [rpa_pkg::STATUS_W-1:0]  out_status,
  output logic [ELEMENT_WIDTH-1:0]      out_granted_element,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ELEMENT_WIDTH-1:0]      cfg_wdata
);

  `include "range_pool_allocator_with_free_list_core_defines.svh"

  localparam int CMD_W = $bits(rpa_pkg::cmd_t);
  localparam int Q_W   = CMD_W + ELEMENT_WIDTH;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  rpa_pkg::cmd_t front_cmd;
  rpa_pkg::cmd_t back_cmd;
  logic [Q_W-1:0] q_rdata;
  logic [ELEMENT_WIDTH-1:0] back_element;

  rpa_front #(
    .MAX_RESERVE (MAX_RESERVE)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .in_op    (in_op),
    .in_count (in_count),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  rpa_cmd_fifo #(
    .WIDTH (Q_W)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({front_cmd, in_element}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign back_cmd     = rpa_pkg::cmd_t'(q_rdata[Q_W-1:ELEMENT_WIDTH]);
  assign back_element = q_rdata[ELEMENT_WIDTH-1:0];

  rpa_back #(
    .ELEMENT_WIDTH   (ELEMENT_WIDTH),
    .FREE_LIST_DEPTH (FREE_LIST_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .q_empty             (q_empty),
    .q_cmd               (back_cmd),
    .q_element           (back_element),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_element (out_granted_element),
    .out_last            (out_last)
  );

  `RPA_ASSERT_NEXT(a_grants_back_to_back, clk, rst_n, out_valid && !out_last, out_valid && out_status == rpa_pkg::STAT_GRANT)
  `RPA_ASSERT_SAME(a_single_result_last, clk, rst_n, out_valid && out_status != rpa_pkg::STAT_GRANT, out_last)
  `RPA_ASSERT_SAME(a_no_element_unless_grant, clk, rst_n, out_valid && out_status != rpa_pkg::STAT_GRANT, out_granted_element == '0)
  `RPA_ASSERT_SAME(a_pop_only_when_filled, clk, rst_n, q_pop, !q_empty)

endmodule
